@@ rtl/mlts_pkg.sv @@
// shared types and constants of the memory laxity task scheduler
package mlts_pkg;

    localparam int DL_W    = 17;
    localparam int LEN_W   = 7;
    localparam int LAX_W   = 18;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 35;
    localparam int SCORE_W = 36;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 128;

    localparam logic [OP_W-1:0] OP_LOAD_TASK = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_INC  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd2;

    localparam logic [DL_W-1:0] DL_MIN = 17'h10000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL,
        S_MW,
        S_ML,
        S_SUM,
        S_SCAN,
        S_TOTAL,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

@@ rtl/memory_laxity_task_scheduler.sv @@
// top level of the memory laxity task scheduler
// Loads (task parameters, step increments) give no result. A tick releases and scores
// each slot in use in the steps S_REL, S_MW, S_ML and S_SUM through one shared multiplier,
// then the selection runs k scans of all slots with one comparator, at most one scheduled
// task per scan (k is the processor count p when at least p tasks compete, otherwise one
// more than the number competing, and zero when p is zero), then the totals are formed,
// each slot is updated in turn and the result is registered, waiting there while the
// previous result is still held. Input ready is low while a tick runs. The increment
// table has no reset; its entries must be loaded before they are used.
module memory_laxity_task_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int MAX_STEPS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // task_index, step_index, deadline, exec_length, release_tick, mem_increment
    input  logic [mlts_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // op
    input  logic [mlts_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tick_number, scheduled_mask, step_memory, running_total, peak_total,
    // missed_tasks, all_finished
    output logic [mlts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [mlts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mlts_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import mlts_pkg::*;

    localparam int IW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int DEPTH = MAX_TASKS * MAX_STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = 16 + CW;

    t_state r_state, n_state;

    logic [4:0]  r_proc_count;
    logic [15:0] r_weight;
    logic [4:0]  r_task_count;

    logic [15:0] r_tick;
    logic [DL_W-1:0]  r_dl      [MAX_TASKS];
    logic [LEN_W-1:0] r_len     [MAX_TASKS];
    logic [15:0]      r_rel     [MAX_TASKS];
    logic [LEN_W-1:0] r_steps   [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_active, r_finished, r_missed, r_cand, r_sched;
    logic signed [SCORE_W-1:0] r_score [MAX_TASKS];
    logic [15:0] r_inc [MAX_TASKS];
    logic [31:0] r_total, r_peak;

    logic [CW-1:0] r_idx, r_pick, r_miss_cnt;
    logic          r_all_fin, r_found, r_inc_oob;
    logic [IW-1:0] r_best_idx;
    logic signed [SCORE_W-1:0] r_best;
    logic signed [PROD_W-1:0]  r_acc;
    logic [ACC_W-1:0] r_step_acc;
    logic [19:0]      r_step_mem;
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic in_acc, out_free, tick_go, mul_weight_sel;
    logic [OP_W-1:0] op;
    logic [3:0]  f_ti;
    logic [5:0]  f_si;
    logic [15:0] f_dl, f_rel, f_inc;
    logic [LEN_W-1:0] f_len;
    logic [IW-1:0] load_idx;
    logic [CW-1:0] eff_n;
    logic last_idx;
    logic [IW-1:0] cur;
    logic rel_hit, act_after;
    logic signed [LAX_W-1:0] lax;
    logic [LEN_W-1:0] rem;
    logic [15:0] mem_rdata, inc_val;
    logic [AW-1:0] waddr, raddr;
    logic mem_we, task_ok;
    t_mul_req mul_req;
    logic signed [PROD_W-1:0] mul_p;
    logic cur_take, fin_found;
    logic [IW-1:0] fin_idx;
    logic [31:0] acc32;
    logic [19:0] step_sat;
    logic [32:0] total_sum;
    logic [LEN_W:0] steps_inc;
    logic upd_fin, upd_miss;
    logic [15:0] mask16;

    assign in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free = !r_out_valid | i_m_axis_tready;
    assign op    = i_s_axis_tuser;
    assign f_ti  = i_s_axis_tdata[3:0];
    assign f_si  = i_s_axis_tdata[9:4];
    assign f_dl  = i_s_axis_tdata[25:10];
    assign f_len = i_s_axis_tdata[32:26];
    assign f_rel = i_s_axis_tdata[48:33];
    assign f_inc = i_s_axis_tdata[64:49];
    assign load_idx = IW'(f_ti);
    assign tick_go = in_acc && (op == OP_TICK);
    assign task_ok = 32'(f_ti) < MAX_TASKS;

    assign eff_n    = (32'(r_task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(r_task_count);
    assign last_idx = (r_idx == eff_n - CW'(1));
    assign cur      = r_idx[IW-1:0];

    assign rel_hit   = !r_active[cur] && !r_finished[cur] && (r_rel[cur] == r_tick);
    assign act_after = r_active[cur] || (rel_hit && (r_steps[cur] < r_len[cur]));
    assign lax = $signed({r_dl[cur][DL_W-1], r_dl[cur]})
               - $signed(LAX_W'(r_len[cur])) + $signed(LAX_W'(r_steps[cur]));
    assign rem = r_len[cur] - r_steps[cur];

    assign mem_we = in_acc && (op == OP_LOAD_INC) && task_ok && (32'(f_si) < MAX_STEPS);
    assign waddr  = AW'(32'(f_ti) * MAX_STEPS + 32'(f_si));
    assign raddr  = AW'(32'(cur) * MAX_STEPS + 32'(r_steps[cur]));

    mlts_inc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (f_inc),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    assign inc_val = r_inc_oob ? 16'd0 : mem_rdata;

    always_comb begin
        if (mul_weight_sel) begin
            mul_req.a = $signed({1'b0, r_weight});
            mul_req.b = $signed({2'b00, inc_val});
        end else begin
            mul_req.a = $signed(MUL_A_W'(rem));
            mul_req.b = lax;
        end
    end

    mlts_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    assign cur_take  = r_cand[cur] && !r_sched[cur] && (!r_found || (r_score[cur] < r_best));
    assign fin_found = r_found || cur_take;
    assign fin_idx   = cur_take ? cur : r_best_idx;

    assign acc32     = 32'(r_step_acc);
    assign step_sat  = (acc32 > 32'hFFFFF) ? 20'hFFFFF : acc32[19:0];
    assign total_sum = {1'b0, r_total} + 33'(step_sat);

    assign steps_inc = {1'b0, r_steps[cur]} + (LEN_W+1)'(1);
    always_comb begin
        upd_fin  = r_finished[cur];
        upd_miss = r_missed[cur];
        if (r_active[cur] && r_sched[cur] && (steps_inc >= {1'b0, r_len[cur]})) begin
            upd_fin = 1'b1;
            if (lax < 0) begin
                upd_miss = 1'b1;
            end
        end
    end

    always_comb begin
        mask16 = '0;
        for (int k = 0; k < 16; k++) begin
            if (k < MAX_TASKS) begin
                mask16[k] = r_sched[k];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (tick_go) begin
                n_state = (eff_n == '0) ? S_TOTAL : S_REL;
            end
            S_REL:   n_state = S_MW;
            S_MW:    n_state = S_ML;
            S_ML:    n_state = S_SUM;
            S_SUM: begin
                if (!last_idx) begin
                    n_state = S_REL;
                end else if (r_proc_count == '0) begin
                    n_state = S_TOTAL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN:  if (last_idx) begin
                if (!fin_found || (32'(r_pick) + 1 >= 32'(r_proc_count))) begin
                    n_state = S_TOTAL;
                end
            end
            S_TOTAL: n_state = (eff_n == '0) ? S_FIN : S_UPD;
            S_UPD:   if (last_idx) begin
                n_state = S_FIN;
            end
            S_FIN:   if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        mul_weight_sel  = (r_state == S_MW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_proc_count <= 5'd4;
            r_weight     <= 16'd1000;
            r_task_count <= 5'd16;
            r_tick       <= '0;
            r_active     <= '0;
            r_finished   <= '0;
            r_missed     <= '0;
            r_total      <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_steps[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROC_COUNT: r_proc_count <= i_cfg_wdata[4:0];
                    CFG_MEM_WEIGHT: r_weight     <= i_cfg_wdata;
                    CFG_TASK_COUNT: r_task_count <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (op == OP_LOAD_TASK) && task_ok) begin
                        r_steps[load_idx]    <= '0;
                        r_active[load_idx]   <= 1'b0;
                        r_finished[load_idx] <= 1'b0;
                        r_missed[load_idx]   <= 1'b0;
                    end
                end
                S_REL: begin
                    if (rel_hit) begin
                        if ({1'b0, r_dl[cur]} < (DL_W+1)'(r_len[cur])) begin
                            r_missed[cur] <= 1'b1;
                        end
                        if (r_steps[cur] >= r_len[cur]) begin
                            r_finished[cur] <= 1'b1;
                        end else begin
                            r_active[cur] <= 1'b1;
                        end
                    end
                end
                S_TOTAL: begin
                    r_total <= total_sum[32] ? 32'hFFFFFFFF : total_sum[31:0];
                    if (!total_sum[32] && (total_sum[31:0] > r_peak)) begin
                        r_peak <= total_sum[31:0];
                    end else if (total_sum[32]) begin
                        r_peak <= 32'hFFFFFFFF;
                    end
                end
                S_UPD: begin
                    if (r_active[cur]) begin
                        if (r_sched[cur]) begin
                            r_steps[cur] <= steps_inc[LEN_W-1:0];
                            if (upd_fin) begin
                                r_active[cur] <= 1'b0;
                            end
                        end
                    end
                    r_finished[cur] <= upd_fin;
                    r_missed[cur]   <= upd_miss;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_tick <= r_tick + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and per-tick working registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (op == OP_LOAD_TASK) && task_ok) begin
            r_dl[load_idx]  <= {1'b0, f_dl};
            r_len[load_idx] <= f_len;
            r_rel[load_idx] <= f_rel;
        end
        case (r_state)
            S_IDLE: begin
                r_idx      <= '0;
                r_pick     <= '0;
                r_found    <= 1'b0;
                r_sched    <= '0;
                r_cand     <= '0;
                r_step_acc <= '0;
                r_miss_cnt <= '0;
                r_all_fin  <= 1'b1;
            end
            S_REL: begin
                r_cand[cur] <= act_after && (r_steps[cur] < r_len[cur]);
                r_inc_oob   <= 32'(r_steps[cur]) >= MAX_STEPS;
            end
            S_MW: begin
                r_inc[cur] <= inc_val;
            end
            S_ML: begin
                r_acc <= mul_p;
            end
            S_SUM: begin
                r_score[cur] <= {r_acc[PROD_W-1], r_acc} + {mul_p[PROD_W-1], mul_p};
                r_idx        <= last_idx ? '0 : r_idx + CW'(1);
            end
            S_SCAN: begin
                if (last_idx) begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (fin_found) begin
                        r_sched[fin_idx] <= 1'b1;
                        r_step_acc <= r_step_acc + ACC_W'(r_inc[fin_idx]);
                        r_pick     <= r_pick + CW'(1);
                    end
                end else begin
                    r_idx <= r_idx + CW'(1);
                    if (cur_take) begin
                        r_found    <= 1'b1;
                        r_best     <= r_score[cur];
                        r_best_idx <= cur;
                    end
                end
            end
            S_TOTAL: begin
                r_idx      <= '0;
                r_step_mem <= step_sat;
            end
            S_UPD: begin
                if (r_active[cur] && (r_dl[cur] != DL_MIN)) begin
                    r_dl[cur] <= r_dl[cur] - DL_W'(1);
                end
                r_miss_cnt <= r_miss_cnt + CW'(upd_miss);
                if (!upd_fin) begin
                    r_all_fin <= 1'b0;
                end
                r_idx <= r_idx + CW'(1);
            end
            S_FIN: begin
                if (out_free) begin
                    r_out <= {6'd0, r_all_fin, 5'(r_miss_cnt), r_peak, r_total,
                              r_step_mem, mask16, r_tick};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;
endmodule

@@ rtl/mlts_mul.sv @@
// shared signed multiplier with registered product
module mlts_mul (
    input  logic                           i_clk,
    input  mlts_pkg::t_mul_req             i_req,
    output logic signed [mlts_pkg::PROD_W-1:0] o_p
);
    import mlts_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_p = r_p;
endmodule

@@ rtl/mlts_inc_mem.sv @@
// memory increment table, one write and one registered read port
module mlts_inc_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mlts_checker.sv @@
// port-level checks of the memory laxity task scheduler
module mlts_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [mlts_pkg::OP_W-1:0]         i_s_axis_tuser,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [mlts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import mlts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == OP_TICK) |=> !o_s_axis_tready)
        else $error("ready stayed high after a tick request");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[115:84] >= o_m_axis_tdata[83:52])
        else $error("worst memory below current memory");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[83:52] >= 32'(o_m_axis_tdata[51:32]))
        else $error("current memory below step memory");
endmodule

bind memory_laxity_task_scheduler mlts_checker u_mlts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
